// ===== design/ostt_pkg.sv =====
package ostt_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int MAX_FIRED = 16;
  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
  localparam int FIRED_W = $clog2(MAX_FIRED + 1);
  localparam int TIME_W = 32;
  localparam int DELAY_W = 24;
  localparam int ID_W = 16;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    STAT_ADDED     = 3'd0,
    STAT_DELETED   = 3'd1,
    STAT_FIRED     = 3'd2,
    STAT_NO_EXPIRY = 3'd3,
    STAT_FULL      = 3'd4,
    STAT_NOT_FOUND = 3'd5,
    STAT_CLEARED   = 3'd6
  } status_t;

  typedef enum logic {
    CTRL_IDLE,
    CTRL_SCAN
  } ctrl_state_t;

  typedef struct packed {
    mode_t                mode;
    logic [DELAY_W-1:0]   delay;
    logic [ID_W-1:0]      timer_id;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [ID_W-1:0]      out_id;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]    deadline;
    logic [ID_W-1:0]      id;
  } entry_t;

  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    entry_t               wdata;
    logic [IDX_W-1:0]     raddr;
  } mem_req_t;

endpackage

// ===== design/ostt_store.sv =====
module ostt_store (
  input  logic              clk,
  input  ostt_pkg::mem_req_t req,
  output ostt_pkg::entry_t  rd_data
);

  ostt_pkg::entry_t mem [ostt_pkg::TIMER_SLOTS];
  ostt_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/ostt_alu.sv =====
module ostt_alu (
  input  logic [ostt_pkg::TIME_W-1:0] a,
  input  logic [ostt_pkg::TIME_W-1:0] b,
  input  logic                        sub,
  output logic [ostt_pkg::TIME_W-1:0] sum
);

  assign sum = a + (sub ? ~b : b) + {{(ostt_pkg::TIME_W-1){1'b0}}, sub};

endmodule

// ===== design/ostt_ctrl.sv =====
module ostt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ostt_pkg::in_item_t  in_item,
  output logic                busy,
  output logic                res_v,
  output ostt_pkg::out_item_t res,
  output ostt_pkg::mem_req_t  mem_req,
  input  ostt_pkg::entry_t    rd_data
);

  ostt_pkg::ctrl_state_t state_r, state_nxt;
  logic [ostt_pkg::TIME_W-1:0]  now_r, now_nxt;
  logic [ostt_pkg::ID_W-1:0]    next_id_r, next_id_nxt;
  logic [ostt_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [ostt_pkg::CNT_W-1:0]   cur_r, cur_nxt;
  logic [ostt_pkg::CNT_W-1:0]   wr_r, wr_nxt;
  ostt_pkg::mode_t              op_r, op_nxt;
  logic [ostt_pkg::ID_W-1:0]    want_r, want_nxt;
  logic                         found_r, found_nxt;
  logic                         pend_v_r, pend_v_nxt;
  logic [ostt_pkg::ID_W-1:0]    pend_id_r, pend_id_nxt;
  logic [ostt_pkg::FIRED_W-1:0] fired_r, fired_nxt;

  logic [ostt_pkg::TIME_W-1:0] alu_a, alu_b, alu_sum;
  logic                        alu_sub;
  logic [ostt_pkg::CNT_W-1:0]  cur_inc;
  logic                        accept;

  ostt_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  assign busy    = (state_r != ostt_pkg::CTRL_IDLE);
  assign accept  = start && !busy;
  assign cur_inc = cur_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ostt_pkg::CTRL_IDLE;
      now_r     <= '0;
      next_id_r <= '0;
      count_r   <= '0;
      pend_v_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      now_r     <= now_nxt;
      next_id_r <= next_id_nxt;
      count_r   <= count_nxt;
      pend_v_r  <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    wr_r      <= wr_nxt;
    op_r      <= op_nxt;
    want_r    <= want_nxt;
    found_r   <= found_nxt;
    pend_id_r <= pend_id_nxt;
    fired_r   <= fired_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    now_nxt     = now_r;
    next_id_nxt = next_id_r;
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    wr_nxt      = wr_r;
    op_nxt      = op_r;
    want_nxt    = want_r;
    found_nxt   = found_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    fired_nxt   = fired_r;

    alu_a   = now_r;
    alu_b   = {{(ostt_pkg::TIME_W-ostt_pkg::DELAY_W){1'b0}}, in_item.delay};
    alu_sub = 1'b0;

    res_v        = 1'b0;
    res.status   = ostt_pkg::STAT_ADDED;
    res.out_id   = '0;
    res.last     = 1'b1;

    mem_req.we          = 1'b0;
    mem_req.waddr       = wr_r[ostt_pkg::IDX_W-1:0];
    mem_req.wdata.deadline = rd_data.deadline;
    mem_req.wdata.id    = rd_data.id;
    mem_req.raddr       = '0;

    case (state_r)
      ostt_pkg::CTRL_IDLE: begin
        if (accept) begin
          case (in_item.mode)
            ostt_pkg::MODE_ADD: begin
              res_v = 1'b1;
              if (count_r == ostt_pkg::CNT_W'(ostt_pkg::TIMER_SLOTS)) begin
                res.status = ostt_pkg::STAT_FULL;
              end else begin
                mem_req.we             = 1'b1;
                mem_req.waddr          = count_r[ostt_pkg::IDX_W-1:0];
                mem_req.wdata.deadline = alu_sum;
                mem_req.wdata.id       = next_id_r;
                count_nxt              = count_r + 1'b1;
                res.out_id             = next_id_r;
                next_id_nxt            = next_id_r + 1'b1;
              end
            end
            ostt_pkg::MODE_CLEAR: begin
              res_v      = 1'b1;
              res.status = ostt_pkg::STAT_CLEARED;
              count_nxt  = '0;
            end
            default: begin
              if (in_item.mode == ostt_pkg::MODE_TICK) begin
                alu_b   = {{(ostt_pkg::TIME_W-1){1'b0}}, 1'b1};
                now_nxt = alu_sum;
              end
              state_nxt  = ostt_pkg::CTRL_SCAN;
              op_nxt     = in_item.mode;
              want_nxt   = in_item.timer_id;
              cur_nxt    = '0;
              wr_nxt     = '0;
              found_nxt  = 1'b0;
              pend_v_nxt = 1'b0;
              fired_nxt  = '0;
            end
          endcase
        end
      end
      ostt_pkg::CTRL_SCAN: begin
        alu_b   = rd_data.deadline;
        alu_sub = 1'b1;
        mem_req.raddr = cur_inc[ostt_pkg::IDX_W-1:0];
        if (cur_r < count_r) begin
          cur_nxt = cur_inc;
          if (op_r == ostt_pkg::MODE_TICK) begin
            if (!alu_sum[ostt_pkg::TIME_W-1] &&
                (fired_r < ostt_pkg::FIRED_W'(ostt_pkg::MAX_FIRED))) begin
              // The previous fired item is sent once a later one is known.
              if (pend_v_r) begin
                res_v      = 1'b1;
                res.status = ostt_pkg::STAT_FIRED;
                res.out_id = pend_id_r;
                res.last   = 1'b0;
              end
              pend_v_nxt  = 1'b1;
              pend_id_nxt = rd_data.id;
              fired_nxt   = fired_r + 1'b1;
            end else begin
              mem_req.we = 1'b1;
              wr_nxt     = wr_r + 1'b1;
            end
          end else begin
            if (!found_r && (rd_data.id == want_r)) begin
              found_nxt = 1'b1;
            end else begin
              mem_req.we = 1'b1;
              wr_nxt     = wr_r + 1'b1;
            end
          end
        end else begin
          count_nxt = wr_r;
          state_nxt = ostt_pkg::CTRL_IDLE;
          res_v     = 1'b1;
          if (op_r == ostt_pkg::MODE_TICK) begin
            if (pend_v_r) begin
              res.status = ostt_pkg::STAT_FIRED;
              res.out_id = pend_id_r;
            end else begin
              res.status = ostt_pkg::STAT_NO_EXPIRY;
            end
            pend_v_nxt = 1'b0;
          end else begin
            res.status = found_r ? ostt_pkg::STAT_DELETED : ostt_pkg::STAT_NOT_FOUND;
          end
        end
      end
      default: begin
        state_nxt = ostt_pkg::CTRL_IDLE;
      end
    endcase
  end

endmodule

// ===== design/one_shot_timer_table.sv =====
// Table of up to sixteen one-shot timers, kept in the order they were added.
// An input item is taken at a rising edge where start is high and busy is low.
// Its mode selects add, delete by id, tick or clear.
// Results leave one per cycle on out_item, marked by out_strobe for exactly one
// cycle; the receiver cannot hold them off, and the last result of each input
// item carries last high.
// Add, table full and clear give their single result in the cycle after the
// item is taken and leave busy low, so one such item can be taken every cycle.
// Delete and tick hold busy while a sequencer walks the entry memory one slot
// per cycle through a single read and write port, compacting the table as
// entries are removed; one 32-bit adder serves the deadline sum, the time
// increment and the expiry compare. Fired results appear during the walk, the
// final one in the cycle in which busy falls. Reset clears the time, the id
// counter and the entry count; the entry memory itself is not cleared, as
// entries beyond the count are never used.
module one_shot_timer_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ostt_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output ostt_pkg::out_item_t out_item
);

  logic                res_v;
  ostt_pkg::out_item_t res;
  ostt_pkg::mem_req_t  mem_req;
  ostt_pkg::entry_t    rd_data;
  logic                out_strobe_r;
  ostt_pkg::out_item_t out_item_r;

  ostt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .res_v   (res_v),
    .res     (res),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  ostt_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (res_v) begin
      out_item_r <= res;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ===== sim/one_shot_timer_table_test.sv =====
`timescale 1ns / 100ps

module one_shot_timer_table_test;
  import ostt_pkg::*;

  class timer_scoreboard;
    logic [TIME_W-1:0] cur_time;
    logic [ID_W-1:0]   id_counter;
    int                tbl_count;
    logic [TIME_W-1:0] tbl_deadline [TIMER_SLOTS];
    logic [ID_W-1:0]   tbl_id [TIMER_SLOTS];
    out_item_t         pending [$];
    int                errors;

    function new();
      cur_time = '0;
      id_counter = '0;
      tbl_count = 0;
      errors = 0;
    endfunction

    function void drop_entry(int pos);
      for (int j = pos; j + 1 < tbl_count; j++) begin
        tbl_deadline[j] = tbl_deadline[j + 1];
        tbl_id[j] = tbl_id[j + 1];
      end
      tbl_count--;
    endfunction

    function void push_result(status_t st, logic [ID_W-1:0] id, logic last);
      out_item_t r;
      r.status = st;
      r.out_id = id;
      r.last = last;
      pending.push_back(r);
    endfunction

    function void note_item(in_item_t it);
      logic [TIME_W-1:0] diff;
      logic [ID_W-1:0]   fired [$];
      int                i;
      bit                found;
      case (it.mode)
        MODE_ADD: begin
          if (tbl_count >= TIMER_SLOTS) begin
            push_result(STAT_FULL, '0, 1'b1);
          end else begin
            tbl_deadline[tbl_count] = cur_time + TIME_W'(it.delay);
            tbl_id[tbl_count] = id_counter;
            tbl_count++;
            push_result(STAT_ADDED, id_counter, 1'b1);
            id_counter = id_counter + 1'b1;
          end
        end
        MODE_DELETE: begin
          found = 1'b0;
          for (i = 0; i < tbl_count && !found; i++) begin
            if (tbl_id[i] == it.timer_id) begin
              drop_entry(i);
              found = 1'b1;
            end
          end
          push_result(found ? STAT_DELETED : STAT_NOT_FOUND, '0, 1'b1);
        end
        MODE_TICK: begin
          cur_time = cur_time + 1'b1;
          i = 0;
          while (i < tbl_count && fired.size() < MAX_FIRED) begin
            diff = cur_time - tbl_deadline[i];
            if (!diff[TIME_W-1]) begin
              fired.push_back(tbl_id[i]);
              drop_entry(i);
            end else begin
              i++;
            end
          end
          if (fired.size() == 0) begin
            push_result(STAT_NO_EXPIRY, '0, 1'b1);
          end
          for (int k = 0; k < fired.size(); k++) begin
            push_result(STAT_FIRED, fired[k], k == fired.size() - 1);
          end
        end
        default: begin
          tbl_count = 0;
          push_result(STAT_CLEARED, '0, 1'b1);
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 100)
          $display("%0t: result with none expected: status %0d id %0d last %0d",
                   $time, got.status, got.out_id, got.last);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        errors++;
        if (errors <= 100)
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.out_id !== want.out_id) begin
        errors++;
        if (errors <= 100)
          $display("%0t: out_id expected %0d actual %0d", $time, want.out_id, got.out_id);
      end
      if (got.last !== want.last) begin
        errors++;
        if (errors <= 100)
          $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_strobe;
  out_item_t out_item;

  timer_scoreboard sb;
  int              idle_pct = 0;

  one_shot_timer_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      sb.check_result(out_item);
    end
  end

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_item <= in_item_t'({$urandom, $urandom});
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
  endtask

  task automatic send_op(mode_t m, logic [DELAY_W-1:0] d, logic [ID_W-1:0] id);
    in_item_t it;
    it.mode = m;
    it.delay = d;
    it.timer_id = id;
    send_item(it);
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    it.delay = DELAY_W'($urandom);
    it.timer_id = ID_W'($urandom);
    r = $urandom_range(99);
    if (r < 40) begin
      it.mode = MODE_ADD;
      if ($urandom_range(9) != 0)
        it.delay = DELAY_W'($urandom_range(6));
    end else if (r < 70) begin
      it.mode = MODE_TICK;
    end else if (r < 92) begin
      it.mode = MODE_DELETE;
      if (sb.tbl_count > 0 && $urandom_range(3) != 0)
        it.timer_id = sb.tbl_id[$urandom_range(sb.tbl_count - 1)];
    end else begin
      it.mode = MODE_CLEAR;
    end
    return it;
  endfunction

  initial begin
    int phase_pct [3];
    phase_pct[0] = 0;
    phase_pct[1] = 55;
    phase_pct[2] = 37;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(MODE_TICK, '0, '0);
    send_op(MODE_ADD, '0, '1);
    send_op(MODE_TICK, '1, '1);
    send_op(MODE_ADD, '1, '0);
    send_op(MODE_DELETE, '0, '1);
    send_op(MODE_DELETE, '1, '0);
    send_op(MODE_DELETE, '0, sb.tbl_id[0]);
    send_op(MODE_CLEAR, '1, '1);
    for (int k = 0; k < TIMER_SLOTS; k++) begin
      send_op(MODE_ADD, (k % 4 == 3) ? DELAY_W'(500) : DELAY_W'(k % 4), ID_W'(k));
    end
    send_op(MODE_ADD, '0, '0);
    send_op(MODE_TICK, '0, '0);
    send_op(MODE_DELETE, '0, sb.tbl_id[1]);
    send_op(MODE_TICK, '0, '0);
    send_op(MODE_CLEAR, '0, '0);

    for (int p = 0; p < 3; p++) begin
      for (int n = 0; n < 25; n++) begin
        if (n % 10 == 0)
          idle_pct = ($urandom_range(3) == 0) ? 0 : phase_pct[p];
        send_item(random_item());
      end
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
